@@ rtl/bounded_double_ended_queue_macros.svh @@
// Assertion macros used by the datapath of the bounded double-ended queue.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check cons in the same cycle as ante.
`define BDEQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdeq assertion failed");

// Check cons in the cycle after ante.
`define BDEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdeq assertion failed");

`else

`define BDEQ_ASSERT_SAME(label, clk, rst, ante, cons)
`define BDEQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/bdeq_pkg.sv @@
// Package with types and constants of the bounded double-ended queue.
package bdeq_pkg;

   localparam int OPCODE_W = 3;
   localparam int DATA_W   = 32;
   localparam int CAP_W    = 11;
   localparam int OCC_W    = 11;

   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK       = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic commit;  // apply the accepted transaction to indices and store
      logic fetch;   // read front and rear slots
      logic load;    // move the result into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;  // output register empty or being drained this cycle
   } status_type;

endpackage

@@ rtl/bdeq_req_if.sv @@
// Request channel interface: operation code and entry value.
interface bdeq_req_if import bdeq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OPCODE_W-1:0]      opcode;
   logic signed [DATA_W-1:0] entry_value;

   modport source (output valid, output opcode, output entry_value, input ready);
   modport sink   (input valid, input opcode, input entry_value, output ready);
endinterface

@@ rtl/bdeq_rsp_if.sv @@
// Response channel interface: result of one queue operation.
interface bdeq_rsp_if import bdeq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     success;
   logic signed [DATA_W-1:0] front_value;
   logic signed [DATA_W-1:0] rear_value;
   logic                     is_empty;
   logic                     is_full;
   logic [OCC_W-1:0]         occupancy;

   modport source (output valid, output success, output front_value, output rear_value,
                   output is_empty, output is_full, output occupancy, input ready);
   modport sink   (input valid, input success, input front_value, input rear_value,
                   input is_empty, input is_full, input occupancy, output ready);
endinterface

@@ rtl/bdeq_ctrl.sv @@
// Controller state machine of the bounded double-ended queue.
module bdeq_ctrl import bdeq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            // refuse transactions while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.commit = 1'b1;
               state_in   = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            // hold until the output register can take the result
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/bdeq_dpath.sv @@
// Datapath: ring indices, entry count, slot memory and output register.
`include "bounded_double_ended_queue_macros.svh"

module bdeq_dpath import bdeq_pkg::*; #(
   parameter int MAX_DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [OPCODE_W-1:0]      req_opcode,
   input  logic signed [DATA_W-1:0] req_entry_value,
   input  logic                     csr_write_enable,
   input  logic [CAP_W-1:0]         csr_write_data,
   input  cmd_type                  cmd,
   output status_type               status,
   bdeq_rsp_if.source               rsp_chan
);

   localparam int IDX_W = $clog2(MAX_DEPTH);
   localparam int CNT_W = $clog2(MAX_DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_DEPTH - 1);

   function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] i);
      ring_inc = (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] i);
      ring_dec = (i == '0) ? LAST_IDX : i - 1'b1;
   endfunction

   logic [DATA_W-1:0] slot_mem [MAX_DEPTH];

   logic [CAP_W-1:0]  capacity_ff;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              success_ff, success_in;
   logic [DATA_W-1:0] front_rd_ff, rear_rd_ff;

   logic                     rsp_valid_ff;
   logic                     rsp_success_ff;
   logic signed [DATA_W-1:0] rsp_front_ff, rsp_rear_ff;
   logic                     rsp_empty_ff, rsp_full_ff;
   logic [OCC_W-1:0]         rsp_occ_ff;

   logic [CMP_W-1:0] cap_eff;
   logic [CMP_W-1:0] count_wide;
   logic             full_c, empty_c;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [31:0]      count_ext;

   assign count_wide = CMP_W'(count_ff);
   assign cap_eff    = (CMP_W'(capacity_ff) > CMP_W'(MAX_DEPTH)) ? CMP_W'(MAX_DEPTH)
                                                                : CMP_W'(capacity_ff);
   assign full_c     = count_wide >= cap_eff;
   assign empty_c    = count_ff == '0;
   assign count_ext  = 32'(count_ff);

   // Operation decode on the accepted transaction.
   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      success_in = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = tail_ff;
      case (op_type'(req_opcode))
         OP_PUSH_FRONT: begin
            if (!full_c) begin
               head_in    = ring_dec(head_ff);
               wr_addr    = ring_dec(head_ff);
               wr_en      = 1'b1;
               count_in   = count_ff + 1'b1;
               success_in = 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (!full_c) begin
               tail_in    = ring_inc(tail_ff);
               wr_addr    = tail_ff;
               wr_en      = 1'b1;
               count_in   = count_ff + 1'b1;
               success_in = 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (!empty_c) begin
               head_in    = ring_inc(head_ff);
               count_in   = count_ff - 1'b1;
               success_in = 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (!empty_c) begin
               tail_in    = ring_dec(tail_ff);
               count_in   = count_ff - 1'b1;
               success_in = 1'b1;
            end
         end
         OP_PEEK: begin
            success_in = 1'b1;
         end
         default: begin
            success_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
      end else begin
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         if (cmd.commit) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         success_ff <= success_in;
      end
   end

   // Slot memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         slot_mem[wr_addr] <= req_entry_value;
      end
      if (cmd.fetch) begin
         front_rd_ff <= slot_mem[head_ff];
         rear_rd_ff  <= slot_mem[ring_dec(tail_ff)];
      end
   end

   // Output register.
   assign status.out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_success_ff <= success_ff;
         rsp_front_ff   <= empty_c ? '1 : front_rd_ff;
         rsp_rear_ff    <= empty_c ? '1 : rear_rd_ff;
         rsp_empty_ff   <= empty_c;
         rsp_full_ff    <= full_c;
         rsp_occ_ff     <= count_ext[OCC_W-1:0];
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.success     = rsp_success_ff;
   assign rsp_chan.front_value = rsp_front_ff;
   assign rsp_chan.rear_value  = rsp_rear_ff;
   assign rsp_chan.is_empty    = rsp_empty_ff;
   assign rsp_chan.is_full     = rsp_full_ff;
   assign rsp_chan.occupancy   = rsp_occ_ff;

   `BDEQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_DEPTH))
   `BDEQ_ASSERT_NEXT(a_refused_holds, clock, reset, cmd.commit && !success_in,
                     $stable(count_ff) && $stable(head_ff) && $stable(tail_ff))
   `BDEQ_ASSERT_NEXT(a_push_grows, clock, reset, cmd.commit && wr_en,
                     count_ff == $past(count_ff) + 1'b1)
   `BDEQ_ASSERT_SAME(a_empty_ones, clock, reset, rsp_valid_ff && rsp_empty_ff,
                     (rsp_front_ff == '1) && (rsp_rear_ff == '1))

endmodule

@@ rtl/bounded_double_ended_queue.sv @@
// Top level of the bounded double-ended queue of signed 32-bit words.
//
// Usage:
//  - req_chan carries one operation per transaction: opcode (push front,
//    push back, pop front, pop back, peek) and entry_value for pushes.
//  - rsp_chan returns exactly one result per request: success, front and
//    rear entries (all ones when empty), empty and full flags, occupancy.
//  - csr_write_enable / csr_write_data set the capacity; write only while
//    no transaction is in flight. Values above MAX_DEPTH act as MAX_DEPTH.
//  - A request walks the controller steps accept, read of the front and rear
//    slots, load of the output register; the load waits while the output
//    register is busy, and a new request is accepted only back in idle.
//  - The slot memory has one write and two registered read ports; a read
//    always lands in the cycle after the write it may depend on.
//  - Reset empties the queue (indices and count to zero), sets capacity to
//    1024 and drops any pending result. No clearing pass is needed.
//  - A stalled receiver holds the result in the output register; one more
//    request is still accepted and waits in the load step until the output
//    register frees up.
module bounded_double_ended_queue import bdeq_pkg::*; #(
   parameter int MAX_DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   bdeq_req_if.sink         req_chan,
   bdeq_rsp_if.source       rsp_chan,
   input  logic             csr_write_enable,
   input  logic [CAP_W-1:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   // Accept ready comes straight from the controller state.
   assign req_chan.ready = req_ready;

   bdeq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bdeq_dpath #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_opcode       (req_chan.opcode),
      .req_entry_value  (req_chan.entry_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_chan         (rsp_chan)
   );

endmodule
